### src/dowq_pkg.sv
// Shared constants for the drop-oldest write queue.
package dowq_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 128;
  localparam int DEFAULT_HANDLE_BITS = 16;

  localparam int CFG_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int OCC_W    = 8;

  localparam logic [CFG_W-1:0] WARN_LEVEL_RST     = 8'd80;
  localparam logic [CFG_W-1:0] MAX_DEPTH_RST      = 8'd100;
  localparam logic [CFG_W-1:0] OVERFLOW_LIMIT_RST = 8'd10;
  localparam logic [CFG_W-1:0] STREAK_MAX         = 8'hFF;

  typedef enum logic [1:0] {
    OP_ENQUEUE  = 2'd0,
    OP_WR_OK    = 2'd1,
    OP_WR_ERROR = 2'd2,
    OP_SESS_RST = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WARN_LEVEL     = 2'd0,
    REG_MAX_DEPTH      = 2'd1,
    REG_OVERFLOW_LIMIT = 2'd2,
    REG_UNUSED         = 2'd3
  } reg_idx_t;

endpackage

### src/drop_oldest_write_queue_core.sv
// Drop-oldest transmit queue of message handles: ring store, counters and result register.
//
// Requests arrive on in_valid/in_ready carrying op and msg_handle; each request
// yields exactly one result on out_valid/out_ready. Ops: enqueue, write ok,
// write error, session reset. An enqueue into a full queue drops the head; after
// overflow_limit consecutive full enqueues the queue closes until a session reset.
// Configuration (warn_level, max_depth, overflow_limit) is written through
// cfg_wr_en/cfg_index/cfg_data; the user must write it only while the block is idle,
// which the block itself does not enforce. A result is held in the p1 stage, loaded
// with the state update and ring store read on acceptance, then in the result register.
// Throughput: one request per cycle unless the receiver stalls; each request touches
// the ring store at most once, a write at the tail for an enqueue or a read of the new
// head for a write ok. When the receiver stalls, the result register and the stage behind
// it hold, and in_ready falls once both are occupied.
// Reset (rst, synchronous) empties the queue, clears the streak and the closed
// state and restores the register defaults; the store itself is not cleared,
// and no clearing pass is needed.
module drop_oldest_write_queue_core
  import dowq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
  parameter int HANDLE_BITS = DEFAULT_HANDLE_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             op,
  input  logic [HANDLE_BITS-1:0] msg_handle,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   send_valid,
  output logic [HANDLE_BITS-1:0] send_handle,
  output logic                   warn_flag,
  output logic                   dropped_flag,
  output logic                   closed_now,
  output logic                   is_closed,
  output logic [OCC_W-1:0]       occupancy
);

  localparam int AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  typedef struct packed {
    logic                   from_mem;
    logic                   send_valid;
    logic [HANDLE_BITS-1:0] handle;
    logic                   warn;
    logic                   dropped;
    logic                   closed_now;
    logic                   is_closed;
    logic [OCC_W-1:0]       occ;
  } res_t;

  // configuration
  logic [CFG_W-1:0] warn_level;
  logic [CFG_W-1:0] max_depth;
  logic [CFG_W-1:0] overflow_limit;

  // queue state
  logic [AW-1:0]    head;
  logic [CNT_W-1:0] count;
  logic [CFG_W-1:0] streak;
  logic             sending;
  logic             shut;

  logic [AW-1:0]    head_next;
  logic [CNT_W-1:0] count_next;
  logic [CFG_W-1:0] streak_next;
  logic             sending_next;
  logic             shut_next;

  // ring store
  logic [HANDLE_BITS-1:0] store [QUEUE_DEPTH];
  logic [HANDLE_BITS-1:0] rd_data;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;

  // result stages
  logic p1_valid;
  res_t p1;
  res_t p1_next;
  res_t out_r;

  logic in_fire;
  logic p1_move;

  assign p1_move  = p1_valid && (!out_valid || out_ready);
  assign in_ready = !p1_valid || p1_move;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      warn_level     <= WARN_LEVEL_RST;
      max_depth      <= MAX_DEPTH_RST;
      overflow_limit <= OVERFLOW_LIMIT_RST;
    end else if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_index))
        REG_WARN_LEVEL:     warn_level     <= cfg_data;
        REG_MAX_DEPTH:      max_depth      <= cfg_data;
        REG_OVERFLOW_LIMIT: overflow_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [CMP_W-1:0] cnt_x;
    logic             full;
    logic [AW-1:0]    head_inc;
    logic [CFG_W-1:0] streak_inc;
    logic [AW:0]      tail_sum;
    logic             idle;

    cnt_x      = CMP_W'(count);
    full       = (cnt_x >= CMP_W'(max_depth)) || (count >= CNT_W'(QUEUE_DEPTH));
    head_inc   = (head == AW'(QUEUE_DEPTH - 1)) ? '0 : head + AW'(1);
    streak_inc = (streak == STREAK_MAX) ? streak : streak + CFG_W'(1);
    idle       = (count == '0);

    head_next    = head;
    count_next   = count;
    streak_next  = streak;
    sending_next = sending;
    shut_next    = shut;

    wr_en    = 1'b0;
    wr_addr  = '0;
    rd_en    = 1'b0;
    rd_addr  = head_inc;
    tail_sum = '0;

    p1_next            = '0;
    p1_next.is_closed  = shut;

    if (in_fire) begin
      case (op_t'(op))
        OP_SESS_RST: begin
          head_next    = '0;
          count_next   = '0;
          sending_next = 1'b0;
          streak_next  = '0;
          shut_next    = 1'b0;
        end
        OP_ENQUEUE: begin
          if (!shut) begin
            p1_next.warn = (cnt_x >= CMP_W'(warn_level));
            if (full) begin
              if (!idle) begin
                head_next       = head_inc;
                count_next      = count - CNT_W'(1);
                p1_next.dropped = 1'b1;
              end
              streak_next = streak_inc;
              if (streak_inc >= overflow_limit) begin
                head_next          = '0;
                count_next         = '0;
                sending_next       = 1'b0;
                shut_next          = 1'b1;
                p1_next.closed_now = 1'b1;
              end
            end else begin
              streak_next = '0;
            end
            if (!shut_next) begin
              // count_next < QUEUE_DEPTH here, so the tail wraps at most once
              tail_sum = {1'b0, head_next} + (AW + 1)'(count_next[AW-1:0]);
              if (tail_sum >= (AW + 1)'(QUEUE_DEPTH))
                tail_sum = tail_sum - (AW + 1)'(QUEUE_DEPTH);
              wr_en      = 1'b1;
              wr_addr    = tail_sum[AW-1:0];
              count_next = count_next + CNT_W'(1);
              if (idle) begin
                sending_next       = 1'b1;
                p1_next.send_valid = 1'b1;
                p1_next.handle     = msg_handle;
              end
            end
          end
        end
        OP_WR_OK: begin
          if (!shut && sending) begin
            if (!idle) begin
              head_next  = head_inc;
              count_next = count - CNT_W'(1);
            end
            if (!idle && count != CNT_W'(1)) begin
              rd_en              = 1'b1;
              p1_next.from_mem   = 1'b1;
              p1_next.send_valid = 1'b1;
            end else begin
              sending_next = 1'b0;
            end
          end
        end
        OP_WR_ERROR: begin
          if (!shut && sending) begin
            head_next          = '0;
            count_next         = '0;
            sending_next       = 1'b0;
            shut_next          = 1'b1;
            p1_next.closed_now = 1'b1;
          end
        end
        default: ;
      endcase
    end

    if (op_t'(op) == OP_SESS_RST)
      p1_next.is_closed = 1'b0;
    else
      p1_next.is_closed = shut_next;
    p1_next.occ = OCC_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (wr_en)
      store[wr_addr] <= msg_handle;
    if (rd_en)
      rd_data <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      count   <= '0;
      streak  <= '0;
      sending <= 1'b0;
      shut    <= 1'b0;
    end else begin
      head    <= head_next;
      count   <= count_next;
      streak  <= streak_next;
      sending <= sending_next;
      shut    <= shut_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire)
        p1_valid <= 1'b1;
      else if (p1_move)
        p1_valid <= 1'b0;
      if (p1_move)
        out_valid <= 1'b1;
      else if (out_ready)
        out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire)
      p1 <= p1_next;
    if (p1_move) begin
      out_r <= p1;
      // read data for a write-ok request is registered in rd_data when the request is accepted
      if (p1.from_mem)
        out_r.handle <= rd_data;
    end
  end

  assign send_valid   = out_r.send_valid;
  assign send_handle  = out_r.handle;
  assign warn_flag    = out_r.warn;
  assign dropped_flag = out_r.dropped;
  assign closed_now   = out_r.closed_now;
  assign is_closed    = out_r.is_closed;
  assign occupancy    = out_r.occ;

endmodule

### src/dowq_checker.sv
// Port-level checks for the drop-oldest write queue, bound to the top level.
module dowq_checker
  import dowq_pkg::*;
#(
  parameter int HANDLE_BITS = DEFAULT_HANDLE_BITS
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic                   send_valid,
  input logic [HANDLE_BITS-1:0] send_handle,
  input logic                   closed_now,
  input logic                   is_closed,
  input logic [OCC_W-1:0]       occupancy
);

  // stalled result must hold
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(send_handle) && $stable(occupancy))
    else $error("result changed while stalled");

  a_idle_handle: assert property (@(posedge clk) disable iff (rst)
    out_valid && !send_valid |-> send_handle == '0)
    else $error("send_handle not zero without a send");

  a_closed_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_closed |-> occupancy == '0 && !send_valid)
    else $error("closed queue reports entries or a send");

  a_close_sticks: assert property (@(posedge clk) disable iff (rst)
    out_valid && closed_now |-> is_closed)
    else $error("close request left the queue open");

endmodule

bind drop_oldest_write_queue_core dowq_checker #(.HANDLE_BITS(HANDLE_BITS)) u_dowq_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .send_valid  (send_valid),
  .send_handle (send_handle),
  .closed_now  (closed_now),
  .is_closed   (is_closed),
  .occupancy   (occupancy)
);
